// ----- sv/bpwq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpwq_pkg
// Shared sizes, status codes and controller states of the buffer pool.
// ----------------------------------------------------------------------------
package bpwq_pkg;

    localparam int POOL_ENTRIES    = 64;
    localparam int WAIT_DEPTH      = 16;
    localparam int REQUESTER_COUNT = 256;

    localparam int EN_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int FC_W = $clog2(POOL_ENTRIES + 1);
    localparam int WQ_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC_W = $clog2(WAIT_DEPTH + 1);
    localparam int RQ_W = (REQUESTER_COUNT > 1) ? $clog2(REQUESTER_COUNT) : 1;

    localparam int S_TDATA_W = ((RQ_W + EN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RQ_W + EN_W + 1 + 7) / 8) * 8;

    typedef enum logic [2:0] {
        STS_GRANTED  = 3'd0,
        STS_QUEUED   = 3'd1,
        STS_FREED    = 3'd2,
        STS_HANDED   = 3'd3,
        STS_REJECTED = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        KIND_ACQUIRE = 1'b0,
        KIND_RETURN  = 1'b1
    } t_kind;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage
`default_nettype wire

// ----- sv/buffer_pool_with_wait_queue_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_pool_with_wait_queue_unit
// Buffer pool allocator with a FIFO free list and a FIFO wait queue.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per transfer; tuser selects acquire (0) or
//   return (1), tdata carries requester id and returned entry index.
//   Master stream: one result per request; tuser carries status and the
//   grant flag, tdata the granted requester, entry and pool busy flag.
//   Config channel: writes the pool size (0 taken as 1, clamped to the pool
//   depth) and reloads the pool as after reset; write it only when idle.
// Timing:
//   A request is taken in the idle state, which reads the free list and
//   wait queue heads from their RAMs; the exec state updates them and loads
//   the output register once it is free. The RAM read is registered, so a
//   new request is taken only after the last one has been updated.
// Reset: free list holds entries 0..63 in order, no waiters, nothing busy.
//   Nothing is swept: a free-list slot never written since the last reload
//   reads as its own index.
// Stall: a result waits in the output register; the next request is still
//   taken, and its update holds until the output register is free.
// ----------------------------------------------------------------------------
module buffer_pool_with_wait_queue_unit
    import bpwq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // requester_id, entry_index, zero pad
    input  wire logic                 i_s_tuser,  // kind
    // master stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata,  // grant_requester, grant_entry, pool_busy, pad
    output logic      [3:0]           o_m_tuser,  // status[2:0], grant_valid
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [FC_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    logic [EN_W-1:0]  r_free_head, n_free_head;
    logic [FC_W-1:0]  r_free_count, n_free_count;
    logic [FC_W-1:0]  r_busy, n_busy;
    logic [WQ_AW-1:0] r_wait_head, n_wait_head;
    logic [WC_W-1:0]  r_wait_count, n_wait_count;
    logic [POOL_ENTRIES-1:0] r_fl_valid, n_fl_valid;

    logic             r_kind;
    logic [RQ_W-1:0]  r_req;
    logic [EN_W-1:0]  r_ent;

    logic                 r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [3:0]           r_out_tuser, n_out_tuser;

    logic             s_accept, cfg_accept, go;
    logic [EN_W-1:0]  fl_rdata, fl_head_val, fl_tail, fl_wdata;
    logic             fl_we;
    logic [RQ_W-1:0]  wq_rdata;
    logic [WQ_AW-1:0] wq_tail;
    logic             wq_we;
    logic [FC_W:0]    fl_sum;
    logic [WC_W:0]    wq_sum;
    logic [FC_W-1:0]  cfg_size;

    t_status          status;
    logic             gv;
    logic [RQ_W-1:0]  greq;
    logic [EN_W-1:0]  gent;

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign go          = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // tail slots, wrapped without a modulo
    assign fl_sum  = (FC_W+1)'(r_free_head) + (FC_W+1)'(r_free_count);
    assign fl_tail = (fl_sum < (FC_W+1)'(POOL_ENTRIES))
                   ? EN_W'(fl_sum) : EN_W'(fl_sum - (FC_W+1)'(POOL_ENTRIES));
    assign wq_sum  = (WC_W+1)'(r_wait_head) + (WC_W+1)'(r_wait_count);
    assign wq_tail = (wq_sum < (WC_W+1)'(WAIT_DEPTH))
                   ? WQ_AW'(wq_sum) : WQ_AW'(wq_sum - (WC_W+1)'(WAIT_DEPTH));

    // a slot not written since the last reload still holds its own index
    assign fl_head_val = r_fl_valid[r_free_head] ? fl_rdata : r_free_head;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = FC_W'(1);
        end else if (i_cfg_data > FC_W'(POOL_ENTRIES)) begin
            cfg_size = FC_W'(POOL_ENTRIES);
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    bpwq_ram #(.WIDTH(EN_W), .DEPTH(POOL_ENTRIES)) u_free_list (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_tail),
        .i_wdata (fl_wdata),
        .i_raddr (r_free_head),
        .o_rdata (fl_rdata)
    );

    bpwq_ram #(.WIDTH(RQ_W), .DEPTH(WAIT_DEPTH)) u_wait_queue (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_tail),
        .i_wdata (r_req),
        .i_raddr (r_wait_head),
        .o_rdata (wq_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_busy       = r_busy;
        n_wait_head  = r_wait_head;
        n_wait_count = r_wait_count;
        n_fl_valid   = r_fl_valid;
        n_out_valid  = r_out_valid;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;
        fl_we        = 1'b0;
        fl_wdata     = r_ent;
        wq_we        = 1'b0;
        status       = STS_REJECTED;
        gv           = 1'b0;
        greq         = '0;
        gent         = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_accept) begin
                    n_free_head  = '0;
                    n_free_count = cfg_size;
                    n_busy       = '0;
                    n_wait_head  = '0;
                    n_wait_count = '0;
                    n_fl_valid   = '0;
                end else if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (go) begin
                    n_state = ST_IDLE;
                    if (r_kind == KIND_ACQUIRE) begin
                        if (r_free_count != '0) begin
                            gent         = fl_head_val;
                            n_free_head  = (r_free_head == EN_W'(POOL_ENTRIES - 1))
                                         ? '0 : r_free_head + 1'b1;
                            n_free_count = r_free_count - 1'b1;
                            n_busy       = r_busy + 1'b1;
                            gv           = 1'b1;
                            greq         = r_req;
                            status       = STS_GRANTED;
                        end else if (r_wait_count != WC_W'(WAIT_DEPTH)) begin
                            wq_we        = 1'b1;
                            n_wait_count = r_wait_count + 1'b1;
                            status       = STS_QUEUED;
                        end
                    end else begin
                        if (r_busy == '0) begin
                            status = STS_REJECTED;
                        end else if (r_wait_count != '0) begin
                            greq         = wq_rdata;
                            n_wait_head  = (r_wait_head == WQ_AW'(WAIT_DEPTH - 1))
                                         ? '0 : r_wait_head + 1'b1;
                            n_wait_count = r_wait_count - 1'b1;
                            gv           = 1'b1;
                            gent         = r_ent;
                            status       = STS_HANDED;
                        end else begin
                            fl_we                = 1'b1;
                            n_fl_valid[fl_tail]  = 1'b1;
                            n_free_count         = r_free_count + 1'b1;
                            n_busy               = r_busy - 1'b1;
                            status               = STS_FREED;
                        end
                    end
                    n_out_valid                          = 1'b1;
                    n_out_tdata                          = '0;
                    n_out_tdata[RQ_W-1:0]                = greq;
                    n_out_tdata[RQ_W+EN_W-1:RQ_W]        = gent;
                    n_out_tdata[RQ_W+EN_W]               = (n_busy != '0);
                    n_out_tuser                          = {gv, status};
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_head  <= '0;
            r_free_count <= FC_W'(POOL_ENTRIES);
            r_busy       <= '0;
            r_wait_head  <= '0;
            r_wait_count <= '0;
            r_fl_valid   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_busy       <= n_busy;
            r_wait_head  <= n_wait_head;
            r_wait_count <= n_wait_count;
            r_fl_valid   <= n_fl_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload: capture on transfer, result on update
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= i_s_tuser;
            r_req  <= i_s_tdata[RQ_W-1:0];
            r_ent  <= i_s_tdata[RQ_W+EN_W-1:RQ_W];
        end
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

endmodule
`default_nettype wire

// ----- sv/bpwq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpwq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- tb/tb_buffer_pool_with_wait_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_buffer_pool_with_wait_queue_unit
// Self-checking bench for the buffer pool with its FIFO wait queue. Requests
// go in on the slave stream from a pending queue, in bursts with random gaps.
// An in-bench model of the free list, the wait queue and the busy count
// predicts each result when its request transfers. Results are checked in
// order against those predictions while the master side stalls at random.
// The pool size is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_buffer_pool_with_wait_queue_unit;
    import bpwq_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_kind            kind;
        logic [RQ_W-1:0]  requester;
        logic [EN_W-1:0]  entry;
    } t_pool_req;

    typedef struct packed {
        t_status          status;
        logic             grant_valid;
        logic [RQ_W-1:0]  grant_requester;
        logic [EN_W-1:0]  grant_entry;
        logic             pool_busy;
    } t_pool_res;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [FC_W-1:0]      i_cfg_data  = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [3:0]           o_m_tuser;
    logic                 o_cfg_ready;

    buffer_pool_with_wait_queue_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [EN_W-1:0] free_mem [POOL_ENTRIES];
    logic [EN_W-1:0] free_head;
    logic [FC_W-1:0] free_cnt;
    logic [RQ_W-1:0] waiter_mem [WAIT_DEPTH];
    logic [WQ_AW-1:0] waiter_head;
    logic [WC_W-1:0] waiter_cnt;
    logic [FC_W-1:0] busy_cnt;

    t_pool_req pending_reqs [$];
    t_pool_res results_due [$];
    int        mismatches = 0;
    int        idle_cycles = 0;

    // sender and receiver pacing
    int burst_left = 1;
    int gap_left   = 0;
    int hold_ask   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_tick    = 0;

    function automatic int effective_size(input logic [FC_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > POOL_ENTRIES)
            return POOL_ENTRIES;
        return int'(v);
    endfunction

    function automatic void reload_pool(input int size);
        for (int i = 0; i < POOL_ENTRIES; i++)
            free_mem[i] = (i < size) ? EN_W'(i) : '0;
        free_head   = '0;
        free_cnt    = FC_W'(size);
        waiter_head = '0;
        waiter_cnt  = '0;
        busy_cnt    = '0;
    endfunction

    function automatic t_pool_res serve_request(input t_pool_req rq);
        t_pool_res r;
        r = '0;
        if (rq.kind == KIND_ACQUIRE) begin
            if (free_cnt != 0) begin
                r.grant_entry     = free_mem[free_head];
                r.grant_valid     = 1'b1;
                r.grant_requester = rq.requester;
                r.status          = STS_GRANTED;
                free_head         = free_head + 1'b1;
                free_cnt          = free_cnt - 1'b1;
                busy_cnt          = busy_cnt + 1'b1;
            end else if (waiter_cnt < WAIT_DEPTH) begin
                waiter_mem[WQ_AW'(waiter_head + waiter_cnt)] = rq.requester;
                waiter_cnt = waiter_cnt + 1'b1;
                r.status   = STS_QUEUED;
            end else begin
                r.status = STS_REJECTED;
            end
        end else begin
            if (busy_cnt == 0) begin
                r.status = STS_REJECTED;
            end else if (waiter_cnt != 0) begin
                // hand the entry straight to the oldest waiter
                r.grant_requester = waiter_mem[waiter_head];
                r.grant_entry     = rq.entry;
                r.grant_valid     = 1'b1;
                r.status          = STS_HANDED;
                waiter_head       = waiter_head + 1'b1;
                waiter_cnt        = waiter_cnt - 1'b1;
            end else begin
                free_mem[EN_W'(free_head + free_cnt)] = rq.entry;
                free_cnt = free_cnt + 1'b1;
                busy_cnt = busy_cnt - 1'b1;
                r.status = STS_FREED;
            end
        end
        r.pool_busy = (busy_cnt != 0);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        t_pool_req rq;
        if (i_rst_n && (!i_s_tvalid || o_s_tready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= rq.kind;
                i_s_tdata  <= S_TDATA_W'({rq.entry, rq.requester});
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern of its own, plus a long hold-off on request
    always @(posedge i_clk) begin
        logic rdy;
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 80);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = (rx_tick % 4 == 0);
            default: rdy = ($urandom_range(0, 9) != 0);
        endcase
        if (hold_left > 0) begin
            rdy = 1'b0;
            hold_left--;
        end
        i_m_tready <= rdy;
    end

    // predict on each request transfer, check on each result transfer
    always @(posedge i_clk) begin
        t_pool_req rq;
        t_pool_res want;
        t_pool_res got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                reload_pool(effective_size(i_cfg_data));
            if (i_s_tvalid && o_s_tready) begin
                rq.kind      = t_kind'(i_s_tuser);
                rq.requester = i_s_tdata[RQ_W-1:0];
                rq.entry     = i_s_tdata[RQ_W +: EN_W];
                results_due.push_back(serve_request(rq));
            end
            if (o_m_tvalid && i_m_tready) begin
                got.status          = t_status'(o_m_tuser[2:0]);
                got.grant_valid     = o_m_tuser[3];
                got.grant_requester = o_m_tdata[RQ_W-1:0];
                got.grant_entry     = o_m_tdata[RQ_W +: EN_W];
                got.pool_busy       = o_m_tdata[RQ_W + EN_W];
                if (results_due.size() == 0) begin
                    note_mismatch($sformatf("result with none pending: %p", got));
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.grant_valid !== want.grant_valid
                        || got.grant_requester !== want.grant_requester
                        || got.grant_entry !== want.grant_entry
                        || got.pool_busy !== want.pool_busy)
                        note_mismatch($sformatf(
                            {"expected sts %0d gv %0b req %0d ent %0d busy %0b, ",
                             "got sts %0d gv %0b req %0d ent %0d busy %0b"},
                            want.status, want.grant_valid, want.grant_requester,
                            want.grant_entry, want.pool_busy, got.status, got.grant_valid,
                            got.grant_requester, got.grant_entry, got.pool_busy));
                end
            end
        end
    end

    // watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("buffer_pool_with_wait_queue_unit test failed");
            $finish;
        end
    end

    task automatic add_req(input t_kind k, input int req, input int ent);
        t_pool_req rq;
        rq.kind      = k;
        rq.requester = RQ_W'(req);
        rq.entry     = EN_W'(ent);
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_s_tvalid || results_due.size() != 0)
            @(negedge i_clk);
        // let the block settle back to idle before touching the pool size
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input int v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= FC_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int size_plan [10];
        int sz;
        int eff;
        int n;
        int acq_pct;
        t_kind k;
        size_plan = '{64, 1, 2, 127, 3, 0, 5, 8, 0, 0};
        size_plan[8] = $urandom_range(0, 127);
        size_plan[9] = $urandom_range(1, 12);
        reload_pool(POOL_ENTRIES);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full pool after reset: return with nothing busy, stray return
        add_req(KIND_RETURN, 0, 5);
        add_req(KIND_ACQUIRE, 255, 0);
        add_req(KIND_RETURN, 0, 63);
        add_req(KIND_RETURN, 255, 0);
        wait_drained();

        // size 0 taken as one entry: fill the wait queue, overflow it, hand off
        write_pool_size(0);
        add_req(KIND_ACQUIRE, 0, 0);
        for (int i = 0; i < WAIT_DEPTH; i++)
            add_req(KIND_ACQUIRE, i * 17, 0);
        add_req(KIND_ACQUIRE, 170, 0);
        add_req(KIND_RETURN, 0, 63);
        add_req(KIND_RETURN, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            sz  = size_plan[ph];
            eff = effective_size(FC_W'(sz));
            write_pool_size(sz);
            n = (eff > 32) ? 220 : 105;
            acq_pct = 50;
            for (int i = 0; i < n; i++) begin
                // shift the acquire bias now and then to fill and drain the pool
                if (i % 20 == 0)
                    acq_pct = (eff > 32) ? $urandom_range(60, 95) : $urandom_range(25, 85);
                k = ($urandom_range(0, 99) < acq_pct) ? KIND_ACQUIRE : KIND_RETURN;
                add_req(k, $urandom_range(0, 255),
                        ($urandom_range(0, 99) < 85) ? $urandom_range(0, eff - 1)
                                                     : $urandom_range(0, 63));
            end
            if (ph == 0)
                hold_ask <= hold_ask + 1;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("buffer_pool_with_wait_queue_unit test passed");
        else
            $display("buffer_pool_with_wait_queue_unit test failed");
        $finish;
    end

endmodule
